// ----- rtl/wcs_pkg.sv -----
// Shared types, constants and the discount table function for the cumulative score block.
package wcs_pkg;

    localparam int GRADE_W  = 4;
    localparam int GSUM_W   = 6;
    localparam int ISUM_W   = 6;
    localparam int ACC_W    = 40;
    localparam int SCORE_W  = 17;
    localparam int COUNT_W  = 11;
    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = SCORE_W;
    localparam int LOG_FRAC    = 30;

    typedef struct packed {
        logic in_range;
        logic last;
        logic overflow;
    } wcs_flags_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_PREP,
        BK_DIV,
        BK_OUT
    } wcs_back_state_t;

    // Discount for zero-based rank r: round(2^fb / log2(r+2)), log taken in Q.30
    // by square-and-compare, quotient by restoring long division.
    function automatic logic [63:0] discount_of_rank(input int unsigned r,
                                                     input int unsigned fb);
        logic [63:0] n;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] l;
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rem;
        int unsigned k;
        int i;
        n    = 64'(r) + 64'd2;
        k    = 0;
        frac = '0;
        q    = '0;
        rem  = '0;
        for (i = 1; i < 64; i++)
        begin
            if ((n >> i) != 64'd0)
            begin
                k = i;
            end
        end
        m = (n << LOG_FRAC) >> k;
        for (i = 0; i < LOG_FRAC; i++)
        begin
            m    = (m * m) >> LOG_FRAC;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m    = m >> 1;
                frac = frac | 64'd1;
            end
        end
        l   = (64'(k) << LOG_FRAC) | frac;
        num = (64'd1 << (fb + LOG_FRAC)) + (l >> 1);
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= l)
            begin
                rem  = rem - l;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

endpackage

// ----- rtl/wcs_front.sv -----
// Front end: accepts ranked items, tracks rank, looks up the discount and classifies.
module wcs_front #(
    parameter int MAX_RANK           = 1024,
    parameter int GRADE_BITS         = 4,
    parameter int DISCOUNT_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,
    input  logic                               s_tlast,
    input  logic                               q_full,
    output logic                               q_push,
    output logic [wcs_pkg::GSUM_W-1:0]         e_gsum,
    output logic [wcs_pkg::ISUM_W-1:0]         e_isum,
    output logic [DISCOUNT_FRAC_BITS:0]        e_disc,
    output logic [$clog2(MAX_RANK+1)-1:0]      e_count,
    output wcs_pkg::wcs_flags_t                e_flags
);

    localparam int DW = DISCOUNT_FRAC_BITS + 1;
    localparam int RW = $clog2(MAX_RANK + 1);
    localparam int AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam logic [wcs_pkg::GRADE_W-1:0] GMASK =
        (GRADE_BITS >= wcs_pkg::GRADE_W) ? '1 : wcs_pkg::GRADE_W'((1 << GRADE_BITS) - 1);

    logic [DW-1:0] disc_rom [MAX_RANK];

    for (genvar gi = 0; gi < MAX_RANK; gi++)
    begin : g_rom
        localparam logic [63:0] DVAL = wcs_pkg::discount_of_rank(gi, DISCOUNT_FRAC_BITS);
        assign disc_rom[gi] = DVAL[DW-1:0];
    end

    logic                        accept;
    logic                        in_range;
    logic [wcs_pkg::GRADE_W-1:0] rel_m;
    logic [wcs_pkg::GRADE_W-1:0] cred_m;
    logic [wcs_pkg::GRADE_W-1:0] third_m;
    logic [wcs_pkg::GSUM_W-1:0]  gsum_next;

    logic [RW-1:0]               rank_reg;
    logic                        ovf_reg;
    logic                        stage_valid_reg;
    logic [wcs_pkg::GSUM_W-1:0]  gsum_reg;
    logic [wcs_pkg::ISUM_W-1:0]  isum_reg;
    logic [DW-1:0]               disc_reg;
    logic [RW-1:0]               count_reg;
    wcs_pkg::wcs_flags_t         flags_reg;

    assign q_push   = stage_valid_reg && !q_full;
    assign s_tready = !stage_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_range = rank_reg < RW'(MAX_RANK);

    assign rel_m   = s_tdata[3:0] & GMASK;
    assign cred_m  = s_tdata[7:4] & GMASK;
    assign third_m = s_tdata[11:8] & GMASK;
    assign gsum_next = wcs_pkg::GSUM_W'(rel_m) + wcs_pkg::GSUM_W'(cred_m)
                     + wcs_pkg::GSUM_W'(third_m);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg        <= '0;
            ovf_reg         <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                stage_valid_reg <= 1'b1;
                if (s_tlast)
                begin
                    rank_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
                else
                begin
                    if (in_range)
                    begin
                        rank_reg <= rank_reg + RW'(1);
                    end
                    ovf_reg <= ovf_reg || !in_range;
                end
            end
            else if (q_push)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gsum_reg           <= gsum_next;
            isum_reg           <= s_tdata[17:12];
            count_reg          <= in_range ? rank_reg + RW'(1) : rank_reg;
            flags_reg.in_range <= in_range;
            flags_reg.last     <= s_tlast;
            flags_reg.overflow <= ovf_reg || !in_range;
            if (in_range)
            begin
                disc_reg <= disc_rom[rank_reg[AW-1:0]];
            end
        end
    end

    assign e_gsum  = gsum_reg;
    assign e_isum  = isum_reg;
    assign e_disc  = disc_reg;
    assign e_count = count_reg;
    assign e_flags = flags_reg;

endmodule

// ----- rtl/wcs_fifo.sv -----
// Short queue between the front end and the back end.
module wcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + (PW+1)'(1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - (PW+1)'(1);
            end
        end
    end

endmodule

// ----- rtl/wcs_back.sv -----
// Back end: weighted accumulation, end-of-list ratio by restoring division, result register.
module wcs_back #(
    parameter int MAX_RANK           = 1024,
    parameter int DISCOUNT_FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  logic [wcs_pkg::GSUM_W-1:0]    e_gsum,
    input  logic [wcs_pkg::ISUM_W-1:0]    e_isum,
    input  logic [DISCOUNT_FRAC_BITS:0]   e_disc,
    input  logic [$clog2(MAX_RANK+1)-1:0] e_count,
    input  wcs_pkg::wcs_flags_t           e_flags,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,
    output logic [1:0]                    m_tuser
);

    localparam int DW = DISCOUNT_FRAC_BITS + 1;
    localparam int RW = $clog2(MAX_RANK + 1);
    localparam int PW = wcs_pkg::GSUM_W + DW;
    localparam int AW = wcs_pkg::ACC_W;
    localparam int SW = wcs_pkg::SCORE_W;

    wcs_pkg::wcs_back_state_t state_reg;
    wcs_pkg::wcs_back_state_t state_next;

    logic          pv_reg;
    logic          plast_reg;
    logic          povf_reg;
    logic [RW-1:0] pcount_reg;
    logic [PW-1:0] gprod_reg;
    logic [PW-1:0] iprod_reg;
    logic [AW-1:0] gain_reg;
    logic [AW-1:0] ideal_reg;
    logic [AW-1:0] rem_reg;
    logic [SW-1:0] quo_reg;
    logic [4:0]    step_reg;
    logic [SW-1:0] score_reg;
    logic          zero_reg;
    logic          ovf_res_reg;
    logic [RW-1:0] cnt_res_reg;

    logic          acc_last;
    logic          ideal_zero;
    logic          ratio_sat;
    logic [AW:0]   gain_sum;
    logic [AW:0]   ideal_wide;
    logic [AW:0]   div_t;
    logic [AW:0]   div_diff;
    logic          div_ge;
    logic [31:0]   cnt_ext;

    assign acc_last   = pv_reg && plast_reg;
    assign ideal_zero = (ideal_reg == '0);
    assign ratio_sat  = {1'b0, gain_reg} >= {ideal_reg, 1'b0};
    assign gain_sum   = {1'b0, gain_reg} + (AW+1)'(gprod_reg);
    assign ideal_wide = {1'b0, ideal_reg} + (AW+1)'(iprod_reg);
    assign div_t      = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
    assign div_ge     = div_t >= {1'b0, ideal_reg};
    assign div_diff   = div_t - {1'b0, ideal_reg};
    assign cnt_ext    = 32'(cnt_res_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wcs_pkg::BK_RUN;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            wcs_pkg::BK_RUN:
            begin
                q_pop = !q_empty && !acc_last;
                if (acc_last)
                begin
                    state_next = wcs_pkg::BK_PREP;
                end
            end
            wcs_pkg::BK_PREP:
            begin
                if (ideal_zero || ratio_sat)
                begin
                    state_next = wcs_pkg::BK_OUT;
                end
                else
                begin
                    state_next = wcs_pkg::BK_DIV;
                end
            end
            wcs_pkg::BK_DIV:
            begin
                if (step_reg == 5'(wcs_pkg::DIV_STEPS - 1))
                begin
                    state_next = wcs_pkg::BK_OUT;
                end
            end
            wcs_pkg::BK_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = wcs_pkg::BK_RUN;
                end
            end
            default:
            begin
                state_next = wcs_pkg::BK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            gain_reg  <= '0;
            ideal_reg <= '0;
        end
        else
        begin
            pv_reg <= q_pop;
            if (state_reg == wcs_pkg::BK_OUT && m_tready)
            begin
                gain_reg  <= '0;
                ideal_reg <= '0;
            end
            else if (pv_reg)
            begin
                gain_reg  <= gain_sum[AW] ? '1 : gain_sum[AW-1:0];
                ideal_reg <= ideal_wide[AW] ? '1 : ideal_wide[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            gprod_reg  <= e_flags.in_range ? PW'(e_gsum) * PW'(e_disc) : '0;
            iprod_reg  <= e_flags.in_range ? PW'(e_isum) * PW'(e_disc) : '0;
            plast_reg  <= e_flags.last;
            povf_reg   <= e_flags.overflow;
            pcount_reg <= e_count;
        end
        if (state_reg == wcs_pkg::BK_RUN && acc_last)
        begin
            cnt_res_reg <= pcount_reg;
            ovf_res_reg <= povf_reg;
        end
        if (state_reg == wcs_pkg::BK_PREP)
        begin
            zero_reg  <= ideal_zero;
            rem_reg   <= gain_reg;
            quo_reg   <= '0;
            step_reg  <= '0;
            score_reg <= (!ideal_zero && ratio_sat) ? '1 : '0;
        end
        if (state_reg == wcs_pkg::BK_DIV)
        begin
            rem_reg  <= div_ge ? div_diff[AW-1:0] : div_t[AW-1:0];
            quo_reg  <= {quo_reg[SW-2:0], div_ge};
            step_reg <= step_reg + 5'd1;
            if (step_reg == 5'(wcs_pkg::DIV_STEPS - 1))
            begin
                score_reg <= {quo_reg[SW-2:0], div_ge};
            end
        end
    end

    assign m_tdata = {4'b0000, cnt_ext[wcs_pkg::COUNT_W-1:0], score_reg};
    assign m_tuser = {ovf_res_reg, zero_reg};

endmodule

// ----- rtl/weighted_cumulative_score_norm.sv -----
// Top level of the multi-aspect normalized weighted cumulative score block.
//
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------------------
//  s_*     | in        | tdata: rel_grade, cred_grade, third_grade, ideal_grade_sum; tlast
//  m_*     | out       | tdata: score, ranked_count; tuser: ideal_was_zero, rank_overflow
//
// Within a list, while the back end is running and the queue has room, one item
// transfer per cycle is taken and accumulated: a discount ROM read, one multiply stage
// and one saturating add each item. After the last item of a list is accumulated the
// back end passes through a compare state and a 17-step restoring divider before the
// result shows; a zero ideal total or a saturated ratio skips the divider.
// Meanwhile the front end keeps taking items of the next list until the 4-entry queue
// and its staging register fill.
// Reset clears rank, accumulators, queue pointers and the back-end state machine at once.
// A stalled result holds in its output register and halts the back end; input transfers
// go on only until the queue and the staging register fill.
module weighted_cumulative_score_norm #(
    parameter int MAX_RANK           = 1024,
    parameter int GRADE_BITS         = 4,
    parameter int DISCOUNT_FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // rel_grade[3:0], cred_grade[7:4], third_grade[11:8],
                                   // ideal_grade_sum[17:12], zero fill
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // score[16:0], ranked_count[27:17], zero fill
    output logic [1:0]  m_tuser    // ideal_was_zero[0], rank_overflow[1]
);

    localparam int DW = DISCOUNT_FRAC_BITS + 1;
    localparam int RW = $clog2(MAX_RANK + 1);
    localparam int GW = wcs_pkg::GSUM_W;
    localparam int IW = wcs_pkg::ISUM_W;
    localparam int EW = RW + DW + IW + GW + 3;

    // Queue entries travel packed: count, discount, ideal sum, grade sum, flags.
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [EW-1:0]       q_wdata;
    logic [EW-1:0]       q_rdata;

    logic [GW-1:0]       f_gsum;
    logic [IW-1:0]       f_isum;
    logic [DW-1:0]       f_disc;
    logic [RW-1:0]       f_count;
    wcs_pkg::wcs_flags_t f_flags;

    logic [GW-1:0]       b_gsum;
    logic [IW-1:0]       b_isum;
    logic [DW-1:0]       b_disc;
    logic [RW-1:0]       b_count;
    wcs_pkg::wcs_flags_t b_flags;

    wcs_front #(
        .MAX_RANK           (MAX_RANK),
        .GRADE_BITS         (GRADE_BITS),
        .DISCOUNT_FRAC_BITS (DISCOUNT_FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .e_gsum   (f_gsum),
        .e_isum   (f_isum),
        .e_disc   (f_disc),
        .e_count  (f_count),
        .e_flags  (f_flags)
    );

    assign q_wdata = {f_count, f_disc, f_isum, f_gsum, f_flags};

    wcs_fifo #(
        .WIDTH (EW),
        .DEPTH (wcs_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    assign b_flags = wcs_pkg::wcs_flags_t'(q_rdata[2:0]);
    assign b_gsum  = q_rdata[3 +: GW];
    assign b_isum  = q_rdata[3 + GW +: IW];
    assign b_disc  = q_rdata[3 + GW + IW +: DW];
    assign b_count = q_rdata[3 + GW + IW + DW +: RW];

    wcs_back #(
        .MAX_RANK           (MAX_RANK),
        .DISCOUNT_FRAC_BITS (DISCOUNT_FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .e_gsum   (b_gsum),
        .e_isum   (b_isum),
        .e_disc   (b_disc),
        .e_count  (b_count),
        .e_flags  (b_flags),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Never write a full queue or read an empty one.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue read while empty");

    // A zero ideal total must come out as a zero score.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[16:0] == 17'd0)
        else $error("nonzero score with zero ideal total");

    // Overflow means the rank table was used up.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[27:17] == 11'(MAX_RANK))
        else $error("rank overflow with short ranked count");

endmodule
